FILE: hdl/ssmt_pkg.sv
// ssmt_pkg: shared types for the set membership table
// command codes, item and result structs, cell control and chain structs
// no dependencies
package ssmt_pkg;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic       was_present;
        logic [4:0] set_count;
        logic       full_refused;
    } t_out;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic cmp;   // compare phase: latch hit and free-slot pick
        logic upd;   // update phase: apply the command
        t_cmd cmd;
        logic miss;  // value absent from the whole row
    } t_cell_ctl;

    // handed from each cell to its right neighbor
    typedef struct packed {
        logic free_seen;
        logic hit_seen;
    } t_chain;

endpackage

FILE: hdl/small_set_membership_table.sv
// small_set_membership_table: set of up to CAPACITY distinct 32-bit values
// a start transfer is registered into a compare state across the cell row, then an
// update state that registers the result strobe; a new start is taken in that state
// busy is high only in the compare cycle; results cannot be stalled
// synchronous active-low reset empties the set; entry values stay undefined
module small_set_membership_table
    import ssmt_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_in,
    output logic o_strobe,
    output t_out o_res
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state      r_state, n_state;
    t_cmd        r_cmd;
    logic [31:0] r_value;
    logic [CW-1:0] r_count, n_count;
    logic        r_any_hit;
    logic        r_any_free;
    logic        r_strobe;
    t_out        r_res, n_res;
    logic        w_accept;
    t_cell_ctl   w_ctl;
    t_chain      w_chain [CAPACITY+1];
    logic [CW+4:0] w_cnt_wide;

    assign busy     = (r_state == S_CMP);
    assign w_accept = start && !busy;

    assign w_ctl.cmp  = (r_state == S_CMP);
    assign w_ctl.upd  = (r_state == S_UPD);
    assign w_ctl.cmd  = r_cmd;
    assign w_ctl.miss = ~r_any_hit;

    assign w_chain[0] = '{free_seen: 1'b0, hit_seen: 1'b0};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ssmt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_value (r_value),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_CMP;
            S_CMP:   n_state = S_UPD;
            S_UPD:   n_state = w_accept ? S_CMP : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count = r_count;
        case (r_cmd)
            CMD_INSERT: if (!r_any_hit && r_any_free) n_count = r_count + CW'(1);
            CMD_REMOVE: if (r_any_hit && r_count != '0) n_count = r_count - CW'(1);
            CMD_CLEAR:  n_count = '0;
            default:    n_count = r_count;
        endcase
    end

    assign w_cnt_wide = (CW + 5)'(n_count);

    always_comb begin
        n_res.was_present  = r_any_hit;
        n_res.set_count    = w_cnt_wide[4:0];
        n_res.full_refused = (r_cmd == CMD_INSERT) && !r_any_hit && !r_any_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_strobe   <= 1'b0;
            r_any_hit  <= 1'b0;
            r_any_free <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_UPD);
            if (r_state == S_CMP) begin
                r_any_hit  <= w_chain[CAPACITY].hit_seen;
                r_any_free <= w_chain[CAPACITY].free_seen;
            end
            if (r_state == S_UPD) r_count <= n_count;
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= t_cmd'(i_in.cmd);
            r_value <= i_in.value;
        end
        if (r_state == S_UPD) r_res <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    a_strobe_after_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_UPD))
        else $error("result strobe without an update cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_refused_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.full_refused) |-> (r_count == CW'(CAPACITY)))
        else $error("insert refused while table not full");

    a_accept_compares: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CMP))
        else $error("accepted transfer did not enter compare");

endmodule

FILE: hdl/ssmt_cell.sv
// ssmt_cell: one entry of the set, value register plus valid flag
// compares against the broadcast value and passes hit/free flags down the row
// depends on ssmt_pkg
module ssmt_cell
    import ssmt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cell_ctl   i_ctl,
    input  logic [31:0] i_value,
    input  t_chain      i_chain,
    output t_chain      o_chain
);

    logic        r_valid;
    logic [31:0] r_value;
    logic        r_hit;
    logic        r_take;
    logic        w_match;

    assign w_match = r_valid && (r_value == i_value);

    assign o_chain.free_seen = i_chain.free_seen | ~r_valid;
    assign o_chain.hit_seen  = i_chain.hit_seen | w_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
            r_take  <= 1'b0;
        end else begin
            if (i_ctl.cmp) begin
                r_hit  <= w_match;
                // lowest free slot: no free cell to the left
                r_take <= ~r_valid & ~i_chain.free_seen;
            end
            if (i_ctl.upd) begin
                case (i_ctl.cmd)
                    CMD_CLEAR: r_valid <= 1'b0;
                    CMD_REMOVE: begin
                        if (r_hit) r_valid <= 1'b0;
                    end
                    CMD_INSERT: begin
                        if (i_ctl.miss && r_take) r_valid <= 1'b1;
                    end
                    default: r_valid <= r_valid;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd && i_ctl.cmd == CMD_INSERT && i_ctl.miss && r_take) begin
            r_value <= i_value;
        end
    end

endmodule
